// ----- hw/rtl/dfla_pkg.sv -----
// shared status and request codes for the descriptor free list allocator
`default_nettype none

package dfla_pkg;

	// width of the result status code
	localparam int unsigned STATUS_W = 2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd2;

	// request kinds carried on the input tuser bit
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/descriptor_free_list_allocator_top.sv -----
// descriptor free list allocator: link memory, list head and free counter
`default_nettype none

// Hands out and takes back descriptor indices kept as a singly linked free list in a
// synchronous link memory (one write port, one registered read port). After reset and
// after every write of the queue size register the block runs a rebuild pass that
// writes one link entry per cycle and keeps s_tready low meanwhile. A free is answered
// at once; an allocate waits in pend_s1, as the link of the current head comes out of
// the memory in the cycle after the head is known. The result waits in an output
// register, so a free request can be taken while the previous result is being handed
// over. Every request gives exactly one result, unless a size write cuts it off.
module descriptor_free_list_allocator_top #(
	parameter int unsigned MAX_DESCRIPTORS = 256,
	localparam int unsigned IDX_W   = $clog2(MAX_DESCRIPTORS),
	localparam int unsigned CNT_W   = $clog2(MAX_DESCRIPTORS + 1),
	localparam int unsigned IN_W    = ((IDX_W + 7) / 8) * 8,
	localparam int unsigned OUT_W   = ((IDX_W + CNT_W + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// queue size register write
	input  wire logic                          cfg_we,
	input  wire logic [CNT_W-1:0]              cfg_wdata,
	// request side
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [IN_W-1:0]               s_tdata,   // free_index
	input  wire logic [0:0]                    s_tuser,   // kind
	// result side
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	output      logic [OUT_W-1:0]              m_tdata,   // granted_index, free_left
	output      logic [dfla_pkg::STATUS_W-1:0] m_tuser    // status
);
	import dfla_pkg::*;

	typedef enum logic {
		ST_INIT,
		ST_RUN
	} state_t;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DESCRIPTORS);

	// link memory
	logic [IDX_W-1:0] link_mem [MAX_DESCRIPTORS];
	logic [IDX_W-1:0] link_rd_q;

	// control and list state
	state_t           state_q;
	logic [IDX_W-1:0] init_cnt_q;
	logic [CNT_W-1:0] size_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] total_q;
	logic             pend_s1;
	logic [IDX_W-1:0] grant_s1;

	// result register
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_grant_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [CNT_W-1:0]    out_left_q;

	// request decode
	logic             req_acc;
	logic             req_free;
	logic [IDX_W-1:0] req_idx;
	logic             list_empty;
	logic             free_bad;
	logic             init_last;
	logic             res_load;
	logic [CNT_W-1:0] size_clamped;

	// memory write port
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_wdata;

	assign s_tready   = (state_q == ST_RUN) && !pend_s1 && (!out_valid_q || m_tready);
	assign req_acc    = s_tvalid && s_tready;
	assign req_free   = (s_tuser[0] == KIND_FREE);
	assign req_idx    = s_tdata[IDX_W-1:0];
	assign list_empty = (total_q == '0) || (CNT_W'(head_q) >= size_q);
	assign free_bad   = (CNT_W'(req_idx) >= size_q) || (total_q >= size_q);
	assign init_last  = (CNT_W'(init_cnt_q) == size_q - CNT_W'(1));
	// a result is loaded when an allocate completes or a free or empty allocate is taken, but not on a size write
	assign res_load   = !cfg_we && (pend_s1 || (req_acc && (req_free || list_empty)));

	// clamp a written size into 1..MAX_DESCRIPTORS
	always_comb begin
		if (cfg_wdata == '0) begin
			size_clamped = CNT_W'(1);
		end else if (cfg_wdata > MAX_CNT) begin
			size_clamped = MAX_CNT;
		end else begin
			size_clamped = cfg_wdata;
		end
	end

	// memory write select: rebuild pass, push on free, unlink on allocate
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = init_cnt_q;
		mem_wdata = init_last ? '0 : init_cnt_q + IDX_W'(1);
		if (state_q == ST_INIT) begin
			mem_we = 1'b1;
		end else if (pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = grant_s1;
			mem_wdata = '0;
		end else if (req_acc && req_free && !free_bad) begin
			mem_we    = 1'b1;
			mem_waddr = req_idx;
			mem_wdata = head_q;
		end
	end

	// link memory, read of the current head every cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		link_rd_q <= link_mem[head_q];
	end

	// control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			init_cnt_q   <= '0;
			size_q       <= MAX_CNT;
			head_q       <= '0;
			total_q      <= '0;
			pend_s1      <= 1'b0;
			grant_s1     <= '0;
			out_valid_q  <= 1'b0;
			out_grant_q  <= '0;
			out_status_q <= STATUS_OK;
			out_left_q   <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				size_q     <= size_clamped;
				state_q    <= ST_INIT;
				init_cnt_q <= '0;
				pend_s1    <= 1'b0;
			end else begin
				case (state_q)
					ST_INIT: begin
						init_cnt_q <= init_cnt_q + IDX_W'(1);
						if (init_last) begin
							state_q <= ST_RUN;
							head_q  <= '0;
							total_q <= size_q;
						end
					end
					ST_RUN: begin
						if (pend_s1) begin
							// allocate completion: head moves to the read link
							pend_s1      <= 1'b0;
							head_q       <= link_rd_q;
							total_q      <= total_q - CNT_W'(1);
							out_grant_q  <= grant_s1;
							out_status_q <= STATUS_OK;
							out_left_q   <= total_q - CNT_W'(1);
						end else if (req_acc) begin
							if (!req_free) begin
								if (list_empty) begin
									out_grant_q  <= '0;
									out_status_q <= STATUS_EMPTY;
									out_left_q   <= total_q;
								end else begin
									pend_s1  <= 1'b1;
									grant_s1 <= head_q;
								end
							end else if (free_bad) begin
								out_grant_q  <= '0;
								out_status_q <= STATUS_BADFREE;
								out_left_q   <= total_q;
							end else begin
								// push the freed index at the head
								head_q       <= req_idx;
								total_q      <= total_q + CNT_W'(1);
								out_grant_q  <= '0;
								out_status_q <= STATUS_OK;
								out_left_q   <= total_q + CNT_W'(1);
							end
						end
					end
					default: begin
						state_q <= ST_INIT;
					end
				endcase
			end
		end
	end

	// result port
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_left_q, out_grant_q});
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dfla_checker.sv -----
// port checker for the descriptor free list allocator and its bind
`default_nettype none

module dfla_checker #(
	parameter int unsigned MAX_DESCRIPTORS = 256,
	localparam int unsigned IDX_W   = $clog2(MAX_DESCRIPTORS),
	localparam int unsigned CNT_W   = $clog2(MAX_DESCRIPTORS + 1),
	localparam int unsigned IN_W    = ((IDX_W + 7) / 8) * 8,
	localparam int unsigned OUT_W   = ((IDX_W + CNT_W + 7) / 8) * 8
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cfg_we,
	input wire logic [CNT_W-1:0]              cfg_wdata,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [IN_W-1:0]               s_tdata,
	input wire logic [0:0]                    s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [OUT_W-1:0]              m_tdata,
	input wire logic [dfla_pkg::STATUS_W-1:0] m_tuser
);
	import dfla_pkg::*;

	logic [IDX_W-1:0] res_grant;
	logic [CNT_W-1:0] res_left;

	assign res_grant = m_tdata[IDX_W-1:0];
	assign res_left  = m_tdata[IDX_W+CNT_W-1:IDX_W];

	// a result that waits keeps its content
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an empty report only when no descriptor is free
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_EMPTY |-> res_left == '0 && res_grant == '0)
		else $error("empty report with free descriptors");

	// rejected frees leave no granted index and codes stay defined
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_EMPTY ||
			(m_tuser == STATUS_BADFREE && res_grant == '0)))
		else $error("bad status or grant on rejected free");

	// a size write starts a rebuild, so no request is taken right after it
	a_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("request taken during rebuild");

	// the free count never exceeds the table
	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_left <= CNT_W'(MAX_DESCRIPTORS))
		else $error("free count out of range");

endmodule

bind descriptor_free_list_allocator_top dfla_checker #(
	.MAX_DESCRIPTORS(MAX_DESCRIPTORS)
) u_dfla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

`default_nettype wire

// ----- tb/dfla_checker.sv -----
// result checker for the descriptor free list allocator: tracks the list and compares replies
`timescale 1ns / 1ps
`default_nettype none

module dfla_scoreboard #(
	parameter int unsigned DESC_MAX = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [8:0]                    cfg_wdata,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [7:0]                    s_tdata,   // free_index
	input  wire logic [0:0]                    s_tuser,   // kind
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [23:0]                   m_tdata,   // granted_index, free_left
	input  wire logic [dfla_pkg::STATUS_W-1:0] m_tuser,   // status
	output int                                 fail_count,
	output int                                 waiting
);
	import dfla_pkg::*;

	typedef struct {
		logic [7:0]          granted;
		logic [STATUS_W-1:0] status;
		logic [8:0]          left;
	} reply_t;

	// shadow copy of the free list
	logic [7:0] link_mem [DESC_MAX];
	logic [7:0] head;
	logic [8:0] free_cnt;
	logic [8:0] size_now;

	reply_t awaited_replies [$];
	reply_t want;
	int     checked;

	// chain every entry in index order for the given raw size
	task automatic rebuild_list(input logic [8:0] raw);
		if (raw == 9'd0)
			size_now = 9'd1;
		else if (raw > 9'(DESC_MAX))
			size_now = 9'(DESC_MAX);
		else
			size_now = raw;
		for (int i = 0; i < DESC_MAX; i++)
			link_mem[i] = (i + 1 < int'(size_now)) ? 8'(i + 1) : 8'd0;
		head = 8'd0;
		free_cnt = size_now;
	endtask

	// pop or push the shadow list and return the reply the request must give
	function automatic reply_t apply_request(input logic kind, input logic [7:0] idx);
		reply_t     r;
		logic [7:0] h;
		r.granted = 8'd0;
		r.status = STATUS_OK;
		if (kind == KIND_ALLOC) begin
			if (free_cnt == 9'd0 || {1'b0, head} >= size_now) begin
				r.status = STATUS_EMPTY;
			end else begin
				h = head;
				head = link_mem[h];
				link_mem[h] = 8'd0;
				free_cnt = free_cnt - 9'd1;
				r.granted = h;
			end
		end else begin
			// out of range or nothing outstanding: ignored
			if ({1'b0, idx} >= size_now || free_cnt >= size_now) begin
				r.status = STATUS_BADFREE;
			end else begin
				link_mem[idx] = head;
				head = idx;
				free_cnt = free_cnt + 9'd1;
			end
		end
		r.left = free_cnt;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int exp_val);
		$display("dfla_scoreboard: %s mismatch on result %0d at %0t: got %0d, want %0d",
			what, checked, $realtime, got, exp_val);
		fail_count++;
	endtask

	// compare replies first, then record the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rebuild_list(9'(DESC_MAX));
			awaited_replies.delete();
			fail_count = 0;
			checked = 0;
			waiting <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_replies.size() == 0) begin
					flag_mismatch("unrequested result", int'(m_tdata[7:0]), 0);
				end else begin
					want = awaited_replies.pop_front();
					if (m_tdata[7:0] != want.granted)
						flag_mismatch("granted_index", int'(m_tdata[7:0]), int'(want.granted));
					if (m_tuser != want.status)
						flag_mismatch("status", int'(m_tuser), int'(want.status));
					if (m_tdata[16:8] != want.left)
						flag_mismatch("free_left", int'(m_tdata[16:8]), int'(want.left));
				end
				checked++;
			end
			if (s_tvalid && s_tready)
				awaited_replies.push_back(apply_request(s_tuser[0], s_tdata));
			if (cfg_we)
				rebuild_list(cfg_wdata);
			waiting <= awaited_replies.size();
		end
	end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// top of the allocator testbench: clock, reset, request and result traffic, verdict
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import dfla_pkg::*;

	localparam int unsigned DESC_MAX      = 256;
	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned RANDOM_PHASES = 10;
	localparam int unsigned PHASE_ITEMS   = 192;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [8:0]          cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // free_index
	logic [0:0]          s_tuser;   // kind
	logic                m_tvalid;
	logic                m_tready;
	logic [23:0]         m_tdata;   // granted_index, free_left
	logic [STATUS_W-1:0] m_tuser;   // status

	int fail_count;
	int waiting;

	// stimulus bookkeeping
	logic       steady;
	logic [7:0] held_idx [$];
	int         prev_left;
	int         size_now;
	int         sent;
	int         settings;
	int         min_size;
	int         max_size;
	int         holds;
	int         cycles;

	descriptor_free_list_allocator_top #(
		.MAX_DESCRIPTORS(DESC_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	dfla_scoreboard #(
		.DESC_MAX(DESC_MAX)
	) u_scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.waiting   (waiting)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	function automatic int pick_gap();
		return steady ? 0 : int'($urandom_range(0, 9));
	endfunction

	// result side: random stalls, remembers indices handed out
	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
			// a successful allocate lowers the free count
			if (m_tuser == STATUS_OK && int'(m_tdata[16:8]) < prev_left)
				held_idx.push_back(m_tdata[7:0]);
			prev_left = int'(m_tdata[16:8]);
		end
	end

	// present one request after a random gap and wait for it to be taken
	task automatic send_request(input logic kind, input logic [7:0] idx);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= idx;
		@(posedge clk);
		while (!(s_tvalid && s_tready)) @(posedge clk);
		sent++;
	endtask

	// stop sending until every outstanding reply is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	task automatic write_queue_size(input logic [8:0] v);
		int sz;
		wait_drained();
		sz = (v == 9'd0) ? 1 : ((v > 9'(DESC_MAX)) ? DESC_MAX : int'(v));
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		held_idx.delete();
		prev_left = sz;
		size_now = sz;
		settings++;
		if (sz < min_size) min_size = sz;
		if (sz > max_size) max_size = sz;
	endtask

	// mostly returns of held indices and allocates, some stray frees
	task automatic random_request();
		int         r;
		int         k;
		logic [7:0] pick;
		r = $urandom_range(0, 99);
		if (r < 45 && held_idx.size() != 0) begin
			k = $urandom_range(0, held_idx.size() - 1);
			pick = held_idx[k];
			held_idx.delete(k);
			send_request(KIND_FREE, pick);
		end else if (r < 88) begin
			send_request(KIND_ALLOC, 8'($urandom));
		end else if (r < 94) begin
			send_request(KIND_FREE, 8'($urandom_range(0, size_now - 1)));
		end else begin
			send_request(KIND_FREE, 8'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [8:0] v;
		cfg_we = 1'b0;
		cfg_wdata = 9'd0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tuser = KIND_ALLOC;
		steady = 1'b0;
		arst_n = 1'b0;
		prev_left = DESC_MAX;
		size_now = DESC_MAX;
		sent = 0;
		settings = 1;
		min_size = DESC_MAX;
		max_size = DESC_MAX;
		holds = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full list after reset: free while full, double free, index extremes
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd255);
		send_request(KIND_ALLOC, 8'd255);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_FREE, 8'd1);

		// single entry: empty allocate, out of range and excess frees
		write_queue_size(9'd1);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd1);
		send_request(KIND_FREE, 8'd255);
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_FREE, 8'd0);

		// size zero clamps up, oversize values clamp down
		write_queue_size(9'd0);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd0);
		write_queue_size(9'd511);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_ALLOC, 8'd0);
		write_queue_size(9'd257);
		send_request(KIND_ALLOC, 8'd255);

		// two entries: drain, double free of the same index, reuse
		write_queue_size(9'd2);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_FREE, 8'd0);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_ALLOC, 8'd0);
		send_request(KIND_FREE, 8'd1);

		// random phases over a spread of queue sizes
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				v = 9'd256;
			end else begin
				case ($urandom_range(0, 4))
					0: v = 9'($urandom_range(1, 4));
					1: v = 9'($urandom_range(5, 32));
					2: v = 9'($urandom_range(33, 255));
					3: v = 9'd256;
					default: v = 9'($urandom_range(0, 511));
				endcase
			end
			write_queue_size(v);
			steady = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2) begin
					wait_drained();
					holds++;
				end
				random_request();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("testbench: %0d requests over %0d queue size settings, %0d to %0d entries",
			sent, settings, min_size, max_size);
		$display("testbench: sender held off %0d times until all replies were back", holds);
		if (fail_count == 0 && waiting == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/dfla_pkg.sv
hw/rtl/descriptor_free_list_allocator_top.sv
hw/rtl/dfla_checker.sv
tb/dfla_checker.sv
tb/testbench.sv
